// File: rtl/core/cgm_pkg.sv
package cgm_pkg;

	// Key and stream widths
	localparam int KEY_W     = 21;
	localparam int ENTRY_MAX = 64;
	localparam int IN_W      = 88;
	localparam int OUT_W     = 72;

	// Command codes
	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_SET    = 1'b1;

	// Status codes
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	// Item sequencer states
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CMP  = 3'b010,
		ST_ACT  = 3'b100
	} cgm_state_t;

	// Broadcast control from the sequencer to every tail cell
	typedef struct packed {
		logic cmp;
		logic upd;
		logic ins;
	} cgm_ctl_t;

endpackage

// File: rtl/core/codepoint_glyph_map_top.sv
// Channel  Dir  Bits  Contents
// s_*      in   88    command, codepoint, entry_in
// m_*      out  72    found, entry_out, status
//
// Each item passes through ST_CMP, which compares the key against every tail
// cell at once, then ST_ACT, which updates or shifts the cell row and loads the result
// register. A new beat is taken in the same cycle the previous result loads.
// A result held by m_tready low holds ST_ACT and so the input.
// Reset clears presence bits, cell valid bits and the sequencer at once.
module codepoint_glyph_map_top #(
	parameter int DIRECT_FIRST = 32,
	parameter int DIRECT_LAST  = 126,
	parameter int TAIL_DEPTH   = 256,
	parameter int ENTRY_WIDTH  = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [cgm_pkg::IN_W-1:0]     s_tdata,  // command, codepoint[20:0], entry_in[63:0]
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [cgm_pkg::OUT_W-1:0]    m_tdata   // found, entry_out[63:0], status
);
	import cgm_pkg::*;

	localparam bit DIRECT_EN    = DIRECT_LAST >= DIRECT_FIRST;
	localparam int DIRECT_DEPTH = DIRECT_EN ? DIRECT_LAST - DIRECT_FIRST + 1 : 1;
	localparam int SLOT_W       = DIRECT_DEPTH > 1 ? $clog2(DIRECT_DEPTH) : 1;
	localparam int GRP          = 16;
	localparam int NGRP         = (TAIL_DEPTH + GRP - 1) / GRP;

	cgm_state_t st_q;
	cgm_ctl_t   ctl;
	logic       s_fire;
	logic       finish;

	logic                   cmd_q;
	logic                   dir_q;
	logic [KEY_W-1:0]       key_q;
	logic [ENTRY_WIDTH-1:0] entry_q;

	logic                   in_dir;
	logic [KEY_W-1:0]       in_key;
	logic [SLOT_W-1:0]      slot;
	logic                   dir_present_s2;
	logic [ENTRY_WIDTH-1:0] dir_data_s2;

	logic [KEY_W-1:0]       c_key   [TAIL_DEPTH];
	logic [ENTRY_WIDTH-1:0] c_entry [TAIL_DEPTH];
	logic [TAIL_DEPTH-1:0]  c_valid;
	logic [TAIL_DEPTH-1:0]  c_lt;
	logic [TAIL_DEPTH-1:0]  c_hit_q;
	logic [TAIL_DEPTH-1:0]  c_hit_c;

	logic [NGRP-1:0]        grp_hit_c;
	logic [ENTRY_WIDTH-1:0] grp_data_c [NGRP];
	logic [NGRP-1:0]        grp_hit_s2;
	logic [ENTRY_WIDTH-1:0] grp_data_s2 [NGRP];

	logic                   tail_hit;
	logic [ENTRY_WIDTH-1:0] tail_data;
	logic                   full;
	logic                   res_found;
	logic [ENTRY_WIDTH-1:0] res_entry;
	logic                   res_status;

	logic                   out_valid_q;
	logic                   out_found_q;
	logic [ENTRY_MAX-1:0]   out_entry_q;
	logic                   out_status_q;

	// Handshake and sequencing
	assign finish   = (st_q == ST_ACT) && (!out_valid_q || m_tready);
	assign s_tready = (st_q == ST_IDLE) || finish;
	assign s_fire   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			case (st_q)
				ST_IDLE: if (s_fire) st_q <= ST_CMP;
				ST_CMP:  st_q <= ST_ACT;
				ST_ACT:  if (finish) st_q <= s_fire ? ST_CMP : ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Capture the input beat
	assign in_key = s_tdata[KEY_W:1];
	assign in_dir = DIRECT_EN && (in_key >= KEY_W'(DIRECT_FIRST))
	                && (in_key <= KEY_W'(DIRECT_LAST));

	always_ff @(posedge clk) begin
		if (s_fire) begin
			cmd_q   <= s_tdata[0];
			key_q   <= in_key;
			entry_q <= s_tdata[KEY_W+1 +: ENTRY_WIDTH];
			dir_q   <= in_dir;
		end
	end

	// Direct-mapped store
	assign slot = dir_q ? SLOT_W'(key_q - KEY_W'(DIRECT_FIRST)) : '0;

	cgm_direct #(
		.DEPTH  (DIRECT_DEPTH),
		.SLOT_W (SLOT_W),
		.ENTRY_W(ENTRY_WIDTH)
	) u_direct (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (st_q == ST_CMP),
		.wr_en     (finish && dir_q && (cmd_q == CMD_SET)),
		.slot      (slot),
		.wdata     (entry_q),
		.present_s2(dir_present_s2),
		.rdata_s2  (dir_data_s2)
	);

	// Tail cell row, cell 0 holds the smallest key
	assign ctl.cmp = (st_q == ST_CMP);
	assign ctl.upd = finish && !dir_q && (cmd_q == CMD_SET) && tail_hit;
	assign ctl.ins = finish && !dir_q && (cmd_q == CMD_SET) && !tail_hit && !full;

	for (genvar i = 0; i < TAIL_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_first
			cgm_cell #(.ENTRY_W(ENTRY_WIDTH)) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.key       (key_q),
				.entry     (entry_q),
				.prev_lt   (1'b1),
				.prev_valid(1'b0),
				.prev_key  ('0),
				.prev_entry('0),
				.valid_q   (c_valid[i]),
				.lt_q      (c_lt[i]),
				.hit_q     (c_hit_q[i]),
				.hit_c     (c_hit_c[i]),
				.key_q     (c_key[i]),
				.entry_q   (c_entry[i])
			);
		end else begin : g_rest
			cgm_cell #(.ENTRY_W(ENTRY_WIDTH)) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.key       (key_q),
				.entry     (entry_q),
				.prev_lt   (c_lt[i-1]),
				.prev_valid(c_valid[i-1]),
				.prev_key  (c_key[i-1]),
				.prev_entry(c_entry[i-1]),
				.valid_q   (c_valid[i]),
				.lt_q      (c_lt[i]),
				.hit_q     (c_hit_q[i]),
				.hit_c     (c_hit_c[i]),
				.key_q     (c_key[i]),
				.entry_q   (c_entry[i])
			);
		end
	end

	assign full = c_valid[TAIL_DEPTH-1];

	// First level of the hit tree: OR within each group of cells
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_hit_c[g]  = 1'b0;
			grp_data_c[g] = '0;
			for (int j = 0; j < GRP; j++) begin
				if (g * GRP + j < TAIL_DEPTH) begin
					grp_hit_c[g]  = grp_hit_c[g] | c_hit_c[g*GRP+j];
					grp_data_c[g] = grp_data_c[g]
					                | (c_entry[g*GRP+j] & {ENTRY_WIDTH{c_hit_c[g*GRP+j]}});
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_CMP) begin
			grp_hit_s2  <= grp_hit_c;
			grp_data_s2 <= grp_data_c;
		end
	end

	// Second level: OR across groups
	always_comb begin
		tail_data = '0;
		for (int g = 0; g < NGRP; g++) begin
			tail_data = tail_data | grp_data_s2[g];
		end
	end
	assign tail_hit = |grp_hit_s2;

	// Form the result
	assign res_found  = dir_q ? dir_present_s2 : tail_hit;
	assign res_entry  = ((cmd_q == CMD_LOOKUP) && res_found)
	                    ? (dir_q ? dir_data_s2 : tail_data) : '0;
	assign res_status = (!dir_q && (cmd_q == CMD_SET) && !tail_hit && full)
	                    ? STATUS_FULL : STATUS_OK;

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_found_q  <= res_found;
			out_entry_q  <= ENTRY_MAX'(res_entry);
			out_status_q <= res_status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(OUT_W - ENTRY_MAX - 2)'(0), out_status_q, out_entry_q, out_found_q};

	// A dropped set never reports a hit
	a_full_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_found_q && out_status_q == STATUS_FULL))
		else $error("dropped set reported found");

	// A nonzero entry only comes with a hit
	a_entry_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_entry_q != '0) |-> out_found_q)
		else $error("entry returned without a hit");

	// Keys in the row are unique
	a_hit_unique: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_ACT) |-> $onehot0(c_hit_q))
		else $error("more than one tail cell matched");

	// A full tail stays full
	a_full_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		full |=> full)
		else $error("tail lost an entry");

	// The row only changes while finishing an item
	a_row_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_ACT) |=> $stable(c_valid))
		else $error("tail row changed outside the act cycle");

endmodule

// File: rtl/core/cgm_direct.sv
module cgm_direct #(
	parameter int DEPTH   = 95,
	parameter int SLOT_W  = 7,
	parameter int ENTRY_W = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  logic               wr_en,
	input  logic [SLOT_W-1:0]  slot,
	input  logic [ENTRY_W-1:0] wdata,
	output logic               present_s2,
	output logic [ENTRY_W-1:0] rdata_s2
);
	import cgm_pkg::*;

	logic [ENTRY_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]   present_q;

	// Presence bits clear at reset, set on first write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q  <= '0;
			present_s2 <= 1'b0;
		end else begin
			if (wr_en) begin
				present_q[slot] <= 1'b1;
			end
			if (rd_en) begin
				present_s2 <= present_q[slot];
			end
		end
	end

	// Entry store, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[slot] <= wdata;
		end
		if (rd_en) begin
			rdata_s2 <= mem[slot];
		end
	end

endmodule

// File: rtl/core/cgm_cell.sv
module cgm_cell #(
	parameter int ENTRY_W = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cgm_pkg::cgm_ctl_t          ctl,
	input  logic [cgm_pkg::KEY_W-1:0]  key,
	input  logic [ENTRY_W-1:0]         entry,
	input  logic                       prev_lt,
	input  logic                       prev_valid,
	input  logic [cgm_pkg::KEY_W-1:0]  prev_key,
	input  logic [ENTRY_W-1:0]         prev_entry,
	output logic                       valid_q,
	output logic                       lt_q,
	output logic                       hit_q,
	output logic                       hit_c,
	output logic [cgm_pkg::KEY_W-1:0]  key_q,
	output logic [ENTRY_W-1:0]         entry_q
);
	import cgm_pkg::*;

	logic lt_c;

	// Compare the broadcast key against the held key
	assign lt_c  = valid_q && (key_q < key);
	assign hit_c = valid_q && (key_q == key);

	// Control: valid bit and compare flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			lt_q    <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			if (ctl.cmp) begin
				lt_q  <= lt_c;
				hit_q <= hit_c;
			end
			// Insert: hold below the slot, load at it, shift in from the lower neighbor above it
			if (ctl.ins && !lt_q) begin
				valid_q <= prev_lt ? 1'b1 : prev_valid;
			end
		end
	end

	// Payload: update in place or shift from the neighbor
	always_ff @(posedge clk) begin
		if (ctl.upd && hit_q) begin
			entry_q <= entry;
		end else if (ctl.ins && !lt_q) begin
			if (prev_lt) begin
				key_q   <= key;
				entry_q <= entry;
			end else begin
				key_q   <= prev_key;
				entry_q <= prev_entry;
			end
		end
	end

endmodule

// File: test/codepoint_glyph_map_checker.sv
`timescale 1ns / 100ps

// Watch both channels, keep a shadow copy of the glyph map, and compare each
// result beat with the oldest predicted outcome.
module codepoint_glyph_map_checker #(
	parameter int DIRECT_FIRST = 32,
	parameter int DIRECT_LAST  = 126,
	parameter int TAIL_DEPTH   = 256,
	parameter int ENTRY_WIDTH  = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	input  logic                      s_tready,
	input  logic [cgm_pkg::IN_W-1:0]  s_tdata,
	input  logic                      m_tvalid,
	input  logic                      m_tready,
	input  logic [cgm_pkg::OUT_W-1:0] m_tdata,
	output int                        mismatches,
	output int                        outstanding,
	output int                        results_checked,
	output int                        hits_seen,
	output int                        drops_seen
);

	localparam int DIRECT_DEPTH =
		(DIRECT_LAST >= DIRECT_FIRST) ? (DIRECT_LAST - DIRECT_FIRST + 1) : 1;
	localparam logic [63:0] ENTRY_MASK =
		(ENTRY_WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << ENTRY_WIDTH) - 64'd1);

	typedef struct packed {
		logic        found;
		logic [63:0] entry;
		logic        status;
	} glyph_outcome_t;

	typedef struct packed {
		logic [cgm_pkg::KEY_W-1:0] key;
		logic [63:0]               entry;
	} tail_slot_t;

	// Shadow state of the map
	logic [63:0]    direct_word [DIRECT_DEPTH];
	bit             direct_valid [DIRECT_DEPTH];
	tail_slot_t     tail_row [$];
	glyph_outcome_t predicted_outcomes [$];

	int fail_count  = 0;
	int queue_depth = 0;
	int checked     = 0;
	int hit_count   = 0;
	int drop_count  = 0;

	assign mismatches      = fail_count;
	assign outstanding     = queue_depth;
	assign results_checked = checked;
	assign hits_seen       = hit_count;
	assign drops_seen      = drop_count;

	// Apply one command to the shadow map and return the outcome it should give
	function automatic glyph_outcome_t apply_command(
		input logic                      cmd,
		input logic [cgm_pkg::KEY_W-1:0] cp,
		input logic [63:0]               word
	);
		glyph_outcome_t res;
		tail_slot_t     slot;
		int             idx;
		int             pos;
		bit             hit;
		res = '0;
		word = word & ENTRY_MASK;
		if (DIRECT_LAST >= DIRECT_FIRST && cp >= DIRECT_FIRST && cp <= DIRECT_LAST) begin
			idx = cp - DIRECT_FIRST;
			res.found = direct_valid[idx];
			if (cmd == cgm_pkg::CMD_SET) begin
				direct_word[idx]  = word;
				direct_valid[idx] = 1'b1;
			end else if (res.found) begin
				res.entry = direct_word[idx];
			end
		end else begin
			// lower bound in the sorted tail
			pos = 0;
			while (pos < tail_row.size() && tail_row[pos].key < cp)
				pos++;
			hit = (pos < tail_row.size()) && (tail_row[pos].key == cp);
			res.found = hit;
			if (cmd == cgm_pkg::CMD_LOOKUP) begin
				if (hit)
					res.entry = tail_row[pos].entry;
			end else if (hit) begin
				tail_row[pos].entry = word;
			end else if (tail_row.size() >= TAIL_DEPTH) begin
				res.status = cgm_pkg::STATUS_FULL;
			end else begin
				slot.key   = cp;
				slot.entry = word;
				tail_row.insert(pos, slot);
			end
		end
		return res;
	endfunction

	// Check results first: a result in the same cycle as a new input
	// always belongs to an older item.
	always @(posedge clk or negedge arst_n) begin
		glyph_outcome_t exp_res;
		glyph_outcome_t got;
		bit             bad;
		if (!arst_n) begin
			for (int i = 0; i < DIRECT_DEPTH; i++)
				direct_valid[i] = 1'b0;
			tail_row.delete();
			predicted_outcomes.delete();
			queue_depth = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.found  = m_tdata[0];
				got.entry  = m_tdata[64:1];
				got.status = m_tdata[65];
				if (predicted_outcomes.size() == 0) begin
					$display("%0t: result beat with nothing expected, actual found=%0b entry=%h status=%0b",
						$time, got.found, got.entry, got.status);
					fail_count++;
				end else begin
					exp_res = predicted_outcomes.pop_front();
					bad = 1'b0;
					if (got.found !== exp_res.found) begin
						$display("%0t: found mismatch, expected %0b, actual %0b",
							$time, exp_res.found, got.found);
						bad = 1'b1;
					end
					if (got.entry !== exp_res.entry) begin
						$display("%0t: entry_out mismatch, expected %h, actual %h",
							$time, exp_res.entry, got.entry);
						bad = 1'b1;
					end
					if (got.status !== exp_res.status) begin
						$display("%0t: status mismatch, expected %0b, actual %0b",
							$time, exp_res.status, got.status);
						bad = 1'b1;
					end
					if (bad)
						fail_count++;
					checked++;
					if (exp_res.found)
						hit_count++;
					if (exp_res.status == cgm_pkg::STATUS_FULL)
						drop_count++;
				end
			end
			if (s_tvalid && s_tready)
				predicted_outcomes.push_back(apply_command(s_tdata[0], s_tdata[21:1],
					s_tdata[85:22]));
			queue_depth = predicted_outcomes.size();
		end
	end

endmodule

// File: test/codepoint_glyph_map_top_test.sv
`timescale 1ns / 100ps

module codepoint_glyph_map_top_test;

	localparam int DIRECT_FIRST = 32;
	localparam int DIRECT_LAST  = 126;
	localparam int TAIL_DEPTH   = 256;
	localparam int ENTRY_WIDTH  = 64;
	localparam int POOL_SIZE    = 300;
	localparam int IDLE_LIMIT   = 1000;
	localparam logic [cgm_pkg::KEY_W-1:0] KEY_TOP = 21'h1FFFFF;

	typedef logic [cgm_pkg::KEY_W-1:0] key_t;

	logic                      clk      = 1'b0;
	logic                      arst_n   = 1'b0;
	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	logic [cgm_pkg::IN_W-1:0]  s_tdata  = '0;  // command, codepoint[20:0], entry_in[63:0]
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	logic [cgm_pkg::OUT_W-1:0] m_tdata;   // found, entry_out[63:0], status

	int mismatches;
	int outstanding;
	int results_checked;
	int hits_seen;
	int drops_seen;

	int items_sent = 0;
	int sets_sent  = 0;
	int idle_count = 0;
	bit calm_send  = 1'b0;
	bit calm_recv  = 1'b0;

	logic [cgm_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
	int                        pool_next = 0;

	codepoint_glyph_map_top #(
		.DIRECT_FIRST(DIRECT_FIRST),
		.DIRECT_LAST (DIRECT_LAST),
		.TAIL_DEPTH  (TAIL_DEPTH),
		.ENTRY_WIDTH (ENTRY_WIDTH)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	codepoint_glyph_map_checker #(
		.DIRECT_FIRST(DIRECT_FIRST),
		.DIRECT_LAST (DIRECT_LAST),
		.TAIL_DEPTH  (TAIL_DEPTH),
		.ENTRY_WIDTH (ENTRY_WIDTH)
	) map_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.mismatches     (mismatches),
		.outstanding    (outstanding),
		.results_checked(results_checked),
		.hits_seen      (hits_seen),
		.drops_seen     (drops_seen)
	);

	always #10 clk = ~clk;

	// Stop the run if no beat moves on either side for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_count <= 0;
			else
				idle_count <= idle_count + 1;
			if (idle_count == IDLE_LIMIT) begin
				$display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// Stall the result channel a random number of cycles per beat
	initial begin
		int stall;
		int taken;
		taken = 0;
		@(negedge clk);
		forever begin
			if (taken % 32 == 0)
				calm_recv = ($urandom_range(0, 3) == 0);
			stall = calm_recv ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			taken++;
			@(negedge clk);
		end
	end

	// Drive one input beat after a random gap; returns at the falling edge
	// after the beat was taken, with tvalid still high.
	task automatic send_beat(
		input logic                      cmd,
		input logic [cgm_pkg::KEY_W-1:0] cp,
		input logic [63:0]               word
	);
		int gap;
		if (items_sent % 32 == 0)
			calm_send = ($urandom_range(0, 3) == 0);
		gap = calm_send ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, word, cp, cmd};
		do @(posedge clk); while (!s_tready);
		items_sent++;
		if (cmd == cgm_pkg::CMD_SET)
			sets_sent++;
		@(negedge clk);
	endtask

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic logic rand_cmd();
		return $urandom_range(0, 1) ? cgm_pkg::CMD_SET : cgm_pkg::CMD_LOOKUP;
	endfunction

	// One random item away from the pool insertion sequence
	task automatic send_mixed();
		logic [cgm_pkg::KEY_W-1:0] cp;
		case ($urandom_range(0, 5))
			0, 1: begin
				cp = key_t'($urandom_range(DIRECT_FIRST, DIRECT_LAST));
				send_beat(rand_cmd(), cp, rand_word());
			end
			2: begin
				send_beat(cgm_pkg::CMD_LOOKUP, key_pool[$urandom_range(0, POOL_SIZE - 1)],
					rand_word());
			end
			3: begin
				// set a pool key that was already sent for insertion into the tail
				if (pool_next > 0)
					send_beat(cgm_pkg::CMD_SET, key_pool[$urandom_range(0, pool_next - 1)],
						rand_word());
				else
					send_beat(cgm_pkg::CMD_LOOKUP, key_pool[0], rand_word());
			end
			4: begin
				// keys around the edges of the direct range and the key space
				case ($urandom_range(0, 2))
					0:       cp = key_t'($urandom_range(0, DIRECT_FIRST - 1));
					1:       cp = key_t'($urandom_range(DIRECT_LAST + 1, DIRECT_LAST + 34));
					default: cp = key_t'($urandom_range(KEY_TOP - 31, KEY_TOP));
				endcase
				send_beat(rand_cmd(), cp, rand_word());
			end
			default: begin
				cp = key_t'($urandom_range(0, KEY_TOP));
				send_beat(rand_cmd(), cp, rand_word());
			end
		endcase
	endtask

	initial begin
		bit                        taken_key [logic [cgm_pkg::KEY_W-1:0]];
		logic [cgm_pkg::KEY_W-1:0] cp;
		int                        j;

		// Distinct tail keys, shuffled, more than the tail can hold
		for (int i = 0; i < POOL_SIZE; i++) begin
			do cp = key_t'($urandom_range(0, KEY_TOP));
			while ((cp >= DIRECT_FIRST && cp <= DIRECT_LAST) || taken_key.exists(cp));
			taken_key[cp] = 1'b1;
			key_pool[i]   = cp;
		end
		for (int i = POOL_SIZE - 1; i > 0; i--) begin
			j           = $urandom_range(0, i);
			cp          = key_pool[i];
			key_pool[i] = key_pool[j];
			key_pool[j] = cp;
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: misses on an empty map, range edges, entry extremes
		send_beat(cgm_pkg::CMD_LOOKUP, key_t'(DIRECT_FIRST), rand_word());
		send_beat(cgm_pkg::CMD_LOOKUP, 21'd0, rand_word());
		send_beat(cgm_pkg::CMD_SET, key_t'(DIRECT_FIRST), {64{1'b1}});
		send_beat(cgm_pkg::CMD_SET, key_t'(DIRECT_LAST), 64'd0);
		send_beat(cgm_pkg::CMD_SET, key_t'(DIRECT_FIRST - 1), rand_word());
		send_beat(cgm_pkg::CMD_SET, key_t'(DIRECT_LAST + 1), {64{1'b1}});
		send_beat(cgm_pkg::CMD_SET, 21'd0, 64'h5555_5555_5555_5555);
		send_beat(cgm_pkg::CMD_SET, KEY_TOP, 64'hAAAA_AAAA_AAAA_AAAA);
		send_beat(cgm_pkg::CMD_SET, 21'h10FFFF, rand_word());
		send_beat(cgm_pkg::CMD_LOOKUP, key_t'(DIRECT_FIRST), rand_word());
		send_beat(cgm_pkg::CMD_LOOKUP, key_t'(DIRECT_LAST), rand_word());
		send_beat(cgm_pkg::CMD_LOOKUP, key_t'(DIRECT_FIRST - 1), rand_word());
		send_beat(cgm_pkg::CMD_LOOKUP, key_t'(DIRECT_LAST + 1), rand_word());
		send_beat(cgm_pkg::CMD_LOOKUP, 21'd0, rand_word());
		send_beat(cgm_pkg::CMD_LOOKUP, KEY_TOP, rand_word());
		send_beat(cgm_pkg::CMD_LOOKUP, 21'h10FFFF, rand_word());
		send_beat(cgm_pkg::CMD_SET, key_t'(DIRECT_FIRST), rand_word());
		send_beat(cgm_pkg::CMD_SET, key_t'(DIRECT_LAST + 1), rand_word());
		send_beat(cgm_pkg::CMD_LOOKUP, key_t'(DIRECT_FIRST), rand_word());
		send_beat(cgm_pkg::CMD_LOOKUP, key_t'(DIRECT_LAST + 1), rand_word());
		send_beat(cgm_pkg::CMD_LOOKUP, key_t'(DIRECT_FIRST + 1), rand_word());
		send_beat(cgm_pkg::CMD_LOOKUP, key_t'(DIRECT_LAST + 2), rand_word());
		send_beat(cgm_pkg::CMD_LOOKUP, 21'd1, rand_word());
		send_beat(cgm_pkg::CMD_SET, 21'd64, rand_word());
		send_beat(cgm_pkg::CMD_LOOKUP, 21'd64, rand_word());

		// Fill the tail past capacity from the pool, mixed with other traffic
		while (pool_next < POOL_SIZE) begin
			if ($urandom_range(0, 1)) begin
				send_beat(cgm_pkg::CMD_SET, key_pool[pool_next], rand_word());
				pool_next++;
			end else begin
				send_mixed();
			end
		end

		// Full tail: updates, lookups and dropped inserts
		repeat (30) begin
			if ($urandom_range(0, 9) < 3)
				send_beat(cgm_pkg::CMD_SET, key_t'($urandom_range(0, KEY_TOP)), rand_word());
			else
				send_mixed();
		end
		s_tvalid <= 1'b0;

		// Drain, then allow the block's latency to pass
		while (outstanding != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d items (%0d sets) over a %0d-key tail pool; checked %0d results",
			items_sent, sets_sent, POOL_SIZE, results_checked);
		$display("Lookup and update hits: %0d, inserts dropped on a full tail: %0d",
			hits_seen, drops_seen);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
